// ===== hw/rtl/iprc_pkg.sv =====
// Shared types, constants and functions for the IPv4 prefix rule classifier.
package iprc_pkg;

    localparam int RULE_SLOTS = 16;
    localparam int SLOT_W     = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

    localparam int ADDR_W     = 32;
    localparam int PREFIX_W   = 6;
    localparam int DIR_W      = 2;
    localparam int ACT_W      = 19;
    localparam int FLAGS_W    = 11;
    localparam int SLOT_IN_W  = 4;
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 16;

    // Bit offsets of the input fields inside the slave tdata word.
    localparam int IN_SLOT_LSB   = 0;
    localparam int IN_EN_LSB     = 4;
    localparam int IN_ADDR_LSB   = 5;
    localparam int IN_PREFIX_LSB = 37;
    localparam int IN_DIR_LSB    = 43;
    localparam int IN_ACT_LSB    = 45;
    localparam int IN_SRC_LSB    = 64;
    localparam int IN_DST_LSB    = 96;
    localparam int IN_FLAGS_LSB  = 128;

    // Direction codes.
    localparam logic [DIR_W-1:0] DIR_EITHER = 2'd0;
    localparam logic [DIR_W-1:0] DIR_SRC    = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DST    = 2'd2;

    // Per-feature action codes.
    localparam logic [1:0] ACT_ON  = 2'd1;
    localparam logic [1:0] ACT_OFF = 2'd2;

    // Quality-score run codes.
    localparam logic [2:0] MOS_A   = 3'd1;
    localparam logic [2:0] MOS_B   = 3'd2;
    localparam logic [2:0] MOS_AB  = 3'd3;
    localparam logic [2:0] MOS_OFF = 3'd4;

    // Flag bit positions.
    localparam logic [3:0] BIT_RTP    = 4'd0;
    localparam logic [3:0] BIT_RTPHDR = 4'd1;
    localparam logic [3:0] BIT_SIP    = 4'd2;
    localparam logic [3:0] BIT_REG    = 4'd3;
    localparam logic [3:0] BIT_WAV    = 4'd4;
    localparam logic [3:0] BIT_GRAPH  = 4'd5;
    localparam logic [3:0] BIT_SKIP   = 4'd6;
    localparam logic [3:0] BIT_SCRIPT = 4'd7;
    localparam logic [3:0] BIT_MOSA   = 4'd8;
    localparam logic [3:0] BIT_MOSB   = 4'd9;
    localparam logic [3:0] BIT_HIDE   = 4'd10;

    // Flag bit driven by each 2-bit action code, in field order.
    localparam logic [3:0] CODE_TARGET [8] = '{
        BIT_RTP, BIT_SIP, BIT_REG, BIT_GRAPH,
        BIT_WAV, BIT_SKIP, BIT_SCRIPT, BIT_HIDE
    };

    typedef struct packed {
        logic [ACT_W-1:0]    actions;
        logic [DIR_W-1:0]    dir;
        logic [PREFIX_W-1:0] prefix;
        logic [ADDR_W-1:0]   addr;
    } t_rule;

    typedef struct packed {
        logic              load;      // input transfer taken this cycle
        logic              rd;        // read rule memory at idx
        logic              take;      // capture the hit at idx as the result
        logic              out_load;  // move the result into the output register
        logic [SLOT_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic in_classify;  // mode of the item offered on the input
        logic hit;          // rule read last cycle is valid and matches
        logic out_free;     // output register can take a result now
    } t_status;

    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] len);
        logic [ADDR_W-1:0] m;
        if (len >= PREFIX_W'(ADDR_W)) begin
            m = {ADDR_W{1'b1}};
        end else begin
            m = ~({ADDR_W{1'b1}} >> len);
        end
        return m;
    endfunction

    function automatic logic [FLAGS_W-1:0] apply_actions(input logic [FLAGS_W-1:0] flags,
                                                         input logic [ACT_W-1:0]   act);
        logic [FLAGS_W-1:0] f;
        logic [1:0]         code;
        logic [2:0]         mos;
        f   = flags;
        mos = act[18:16];
        for (int i = 0; i < 8; i++) begin
            code = act[2*i +: 2];
            if (code == ACT_ON) begin
                f[CODE_TARGET[i]] = 1'b1;
            end else if (code == ACT_OFF) begin
                f[CODE_TARGET[i]] = 1'b0;
                // Turning rtp off also drops the header-only capture.
                if (i == 0) begin
                    f[BIT_RTPHDR] = 1'b0;
                end
            end
        end
        // Score runs come last; runs A, B and AB also force recording on.
        case (mos)
            MOS_A: begin
                f[BIT_MOSA] = 1'b1;
                f[BIT_WAV]  = 1'b1;
            end
            MOS_B: begin
                f[BIT_MOSB] = 1'b1;
                f[BIT_WAV]  = 1'b1;
            end
            MOS_AB: begin
                f[BIT_MOSA] = 1'b1;
                f[BIT_MOSB] = 1'b1;
                f[BIT_WAV]  = 1'b1;
            end
            MOS_OFF: begin
                f[BIT_MOSA] = 1'b0;
                f[BIT_MOSB] = 1'b0;
            end
            default: begin
            end
        endcase
        return f;
    endfunction

endpackage

// ===== hw/rtl/ip_prefix_rule_classifier.sv =====
// Top level of the IPv4 first-match prefix rule classifier.
//
// One input stream carries both rule writes and classify requests; tuser selects
// the kind (0 writes the rule in tdata into its slot, 1 classifies the addresses
// and flags in tdata). Every input transfer yields exactly one output transfer:
// matched, match_slot and flags_out packed in tdata. A write answers all zero.
// Rules are kept in a 16-entry memory with one read port, and the sequencer
// walks slots from 0 upward, reading then testing each slot, stopping at
// the first valid matching slot. Input ready returns in the cycle after the
// result is handed to the output register, so a new item is taken only once
// the last item's result has moved into that register.
// The output register holds a finished result while the receiver stalls, and
// the next input transfer is taken meanwhile; that item then waits for the
// register before its own result moves in.
// Synchronous reset clears all valid bits, so no rule matches until written;
// it also empties the output register.
module ip_prefix_rule_classifier
    import iprc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // slot[3:0], rule_enable[4], rule_addr[36:5], rule_prefix_len[42:37],
    // rule_direction[44:43], rule_actions[63:45], src_addr[95:64],
    // dst_addr[127:96], flags_in[138:128], zero fill[143:139]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // mode[0]
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // matched[0], match_slot[4:1], flags_out[15:5]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    t_cmd    cmd;
    t_status st;

    iprc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_st            (st),
        .o_cmd           (cmd)
    );

    iprc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_st            (st),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

// ===== hw/rtl/iprc_ctrl.sv =====
// Sequencer that walks the rule slots in priority order for each classify transfer.
module iprc_ctrl
    import iprc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_axis_tvalid,
    output logic    o_s_axis_tready,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_TEST,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_idx, n_idx;

    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        o_cmd          = '0;
        o_cmd.idx      = r_idx;
        o_s_axis_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    // A rule write is done at the transfer itself.
                    n_state    = i_st.in_classify ? S_READ : S_DONE;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_TEST;
            end
            S_TEST: begin
                if (i_st.hit) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_DONE;
                end else if (r_idx == SLOT_W'(RULE_SLOTS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    a_take_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |=> (r_state == S_DONE))
        else $error("hit capture not followed by result hand-off");

    a_read_then_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_TEST) && $stable(r_idx))
        else $error("slot index moved between memory read and test");

    a_load_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state != S_IDLE))
        else $error("input transfer taken without starting its item");

endmodule

// ===== hw/rtl/iprc_dp.sv =====
// Rule memory, valid bits, match logic, flag update and output register.
module iprc_dp
    import iprc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_st,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                  i_s_axis_tuser,
    input  logic                  i_m_axis_tready,
    output logic                  o_m_axis_tvalid,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    t_rule                  r_mem [RULE_SLOTS];
    logic [RULE_SLOTS-1:0]  r_valid;

    t_rule                  r_rd;
    logic                   r_rd_vld;

    logic [ADDR_W-1:0]      r_src, r_dst;
    logic [FLAGS_W-1:0]     r_flags;

    logic                   r_res_matched;
    logic [SLOT_IN_W-1:0]   r_res_slot;
    logic [FLAGS_W-1:0]     r_res_flags;

    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;

    t_rule                  in_rule;
    logic [SLOT_IN_W-1:0]   in_slot;
    logic                   in_enable;
    logic                   wr_en;
    logic [ADDR_W-1:0]      mask;
    logic                   s_ok, d_ok, dir_ok;

    assign in_slot         = i_s_axis_tdata[IN_SLOT_LSB +: SLOT_IN_W];
    assign in_enable       = i_s_axis_tdata[IN_EN_LSB];
    assign in_rule.addr    = i_s_axis_tdata[IN_ADDR_LSB +: ADDR_W];
    assign in_rule.prefix  = i_s_axis_tdata[IN_PREFIX_LSB +: PREFIX_W];
    assign in_rule.dir     = i_s_axis_tdata[IN_DIR_LSB +: DIR_W];
    assign in_rule.actions = i_s_axis_tdata[IN_ACT_LSB +: ACT_W];

    // Slots beyond the table are dropped.
    assign wr_en = i_cmd.load && !i_s_axis_tuser && (int'(in_slot) < RULE_SLOTS);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[SLOT_W'(in_slot)] <= in_rule;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[i_cmd.idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_valid[SLOT_W'(in_slot)] <= in_enable;
            end
            if (i_cmd.rd) begin
                r_rd_vld <= r_valid[i_cmd.idx];
            end
        end
    end

    assign mask = prefix_mask(r_rd.prefix);
    assign s_ok = ((r_src & mask) == (r_rd.addr & mask));
    assign d_ok = ((r_dst & mask) == (r_rd.addr & mask));

    always_comb begin
        case (r_rd.dir)
            DIR_EITHER: dir_ok = s_ok || d_ok;
            DIR_SRC:    dir_ok = s_ok;
            DIR_DST:    dir_ok = d_ok;
            default:    dir_ok = 1'b0;
        endcase
    end

    assign o_st.in_classify = i_s_axis_tuser;
    assign o_st.hit         = r_rd_vld && dir_ok;
    assign o_st.out_free    = !r_out_valid || i_m_axis_tready;

    // Result registers: preset to the no-match answer, overwritten on a hit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_src         <= i_s_axis_tdata[IN_SRC_LSB +: ADDR_W];
            r_dst         <= i_s_axis_tdata[IN_DST_LSB +: ADDR_W];
            r_flags       <= i_s_axis_tdata[IN_FLAGS_LSB +: FLAGS_W];
            r_res_matched <= 1'b0;
            r_res_slot    <= '0;
            r_res_flags   <= i_s_axis_tuser ? i_s_axis_tdata[IN_FLAGS_LSB +: FLAGS_W]
                                            : '0;
        end else if (i_cmd.take) begin
            r_res_matched <= 1'b1;
            r_res_slot    <= SLOT_IN_W'(i_cmd.idx);
            r_res_flags   <= apply_actions(r_flags, r_rd.actions);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {r_res_flags, r_res_slot, r_res_matched};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_m_axis_tready))
        else $error("pending result overwritten");

    a_take_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take |-> o_st.hit)
        else $error("result captured without a matching valid rule");

    a_miss_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data[0]) |-> (r_out_data[SLOT_IN_W:1] == '0))
        else $error("miss result carries a nonzero slot");

endmodule

// ===== dv/ip_prefix_rule_classifier_tb.sv =====
// Self-checking testbench for the IPv4 first-match prefix rule classifier.
`timescale 1ns / 100ps

module ip_prefix_rule_classifier_tb
    import iprc_pkg::*;
();

    localparam logic       MODE_WRITE    = 1'b0;
    localparam logic       MODE_CLASSIFY = 1'b1;
    localparam logic [1:0] DIR_NEVER     = 2'd3;
    localparam logic [1:0] CODE_NONE     = 2'd0;
    localparam logic [1:0] CODE_RSVD     = 2'd3;
    localparam logic [2:0] MOS_NONE      = 3'd0;
    localparam logic [2:0] MOS_RSVD_LO   = 3'd5;
    localparam logic [2:0] MOS_RSVD_HI   = 3'd7;
    localparam int         RANDOM_ITEMS  = 830;
    localparam int         DRAIN_CYCLES  = 40;

    // Flag bit touched by each 2-bit feature code, from the low code up.
    localparam logic [3:0] FEATURE_BIT [8] = '{
        BIT_RTP, BIT_SIP, BIT_REG, BIT_GRAPH,
        BIT_WAV, BIT_SKIP, BIT_SCRIPT, BIT_HIDE
    };

    typedef struct packed {
        logic                 pause;  // wait for every result before going on
        logic                 mode;
        logic [SLOT_IN_W-1:0] slot;
        logic                 en;
        logic [ADDR_W-1:0]    addr;
        logic [PREFIX_W-1:0]  plen;
        logic [DIR_W-1:0]     dir;
        logic [ACT_W-1:0]     act;
        logic [ADDR_W-1:0]    src;
        logic [ADDR_W-1:0]    dst;
        logic [FLAGS_W-1:0]   flags;
    } call_item_t;

    // Laid out like the result tdata word: matched in the lowest bit.
    typedef struct packed {
        logic [FLAGS_W-1:0]   flags;
        logic [SLOT_IN_W-1:0] slot;
        logic                 matched;
    } verdict_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [IN_DATA_W-1:0]  s_data = '0;
    logic                  s_user = 1'b0;
    logic                  s_ready;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;

    call_item_t  pending_items [$];
    verdict_t    expected_verdicts [$];
    call_item_t  cur_item;
    t_rule       rule_table [RULE_SLOTS];
    logic [RULE_SLOTS-1:0] rule_live = '0;
    logic [ADDR_W-1:0]     seed_addr [RULE_SLOTS];
    int unsigned n_accepted = 0;
    int unsigned n_checked = 0;
    int unsigned n_err = 0;
    int unsigned cyc = 0;
    int unsigned hold_left = 0;

    ip_prefix_rule_classifier uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // slot, rule_enable, rule_addr, prefix, dir, actions,
                                     // src_addr, dst_addr, flags_in
        .i_s_axis_tuser  (s_user),   // mode
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)    // matched, match_slot, flags_out
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("MISMATCH %s: expected 0x%0h, got 0x%0h (result %0d)",
                 what, want, got, n_checked);
        n_err++;
    endtask

    function automatic logic [FLAGS_W-1:0] run_actions(input logic [FLAGS_W-1:0] f,
                                                       input logic [ACT_W-1:0]   act);
        for (int i = 0; i < 8; i++) begin
            if (act[2*i +: 2] == ACT_ON) begin
                f[FEATURE_BIT[i]] = 1'b1;
            end else if (act[2*i +: 2] == ACT_OFF) begin
                f[FEATURE_BIT[i]] = 1'b0;
                if (FEATURE_BIT[i] == BIT_RTP) begin
                    f[BIT_RTPHDR] = 1'b0;
                end
            end
        end
        // Score runs are applied last; runs A, B and AB also turn recording back on.
        case (act[18:16])
            MOS_A: begin
                f[BIT_MOSA] = 1'b1;
                f[BIT_WAV]  = 1'b1;
            end
            MOS_B: begin
                f[BIT_MOSB] = 1'b1;
                f[BIT_WAV]  = 1'b1;
            end
            MOS_AB: begin
                f[BIT_MOSA] = 1'b1;
                f[BIT_MOSB] = 1'b1;
                f[BIT_WAV]  = 1'b1;
            end
            MOS_OFF: begin
                f[BIT_MOSA] = 1'b0;
                f[BIT_MOSB] = 1'b0;
            end
            default: begin
            end
        endcase
        return f;
    endfunction

    function automatic verdict_t classify_call(input logic [ADDR_W-1:0]  src,
                                               input logic [ADDR_W-1:0]  dst,
                                               input logic [FLAGS_W-1:0] flags);
        verdict_t          v;
        logic [ADDR_W-1:0] m;
        logic              s_ok;
        logic              d_ok;
        logic              hit;
        v = '{matched: 1'b0, slot: '0, flags: flags};
        // Walk from the top so the lowest matching slot is the one left standing.
        for (int s = RULE_SLOTS - 1; s >= 0; s--) begin
            // A shift of 32 or more empties the word, so long prefixes saturate.
            m    = ~(32'hFFFF_FFFF >> rule_table[s].prefix);
            s_ok = ((src & m) == (rule_table[s].addr & m));
            d_ok = ((dst & m) == (rule_table[s].addr & m));
            case (rule_table[s].dir)
                DIR_EITHER: hit = s_ok || d_ok;
                DIR_SRC:    hit = s_ok;
                DIR_DST:    hit = d_ok;
                default:    hit = 1'b0;
            endcase
            if (rule_live[s] && hit) begin
                v.matched = 1'b1;
                v.slot    = SLOT_IN_W'(s);
                v.flags   = run_actions(flags, rule_table[s].actions);
            end
        end
        return v;
    endfunction

    task automatic add_rule(input logic [3:0] slot, input logic en, input logic [31:0] addr,
                            input logic [5:0] plen, input logic [1:0] dir,
                            input logic [18:0] act);
        call_item_t it;
        it = '{pause: 1'b0, mode: MODE_WRITE, slot: slot, en: en, addr: addr, plen: plen,
               dir: dir, act: act, src: $urandom, dst: $urandom,
               flags: FLAGS_W'($urandom)};
        seed_addr[slot] = addr;
        pending_items = {pending_items, it};
    endtask

    task automatic add_call(input logic [31:0] src, input logic [31:0] dst,
                            input logic [10:0] flags);
        call_item_t it;
        it = '{pause: 1'b0, mode: MODE_CLASSIFY, slot: SLOT_IN_W'($urandom),
               en: 1'($urandom), addr: $urandom, plen: PREFIX_W'($urandom),
               dir: DIR_W'($urandom), act: ACT_W'($urandom),
               src: src, dst: dst, flags: flags};
        pending_items = {pending_items, it};
    endtask

    task automatic add_pause();
        call_item_t it;
        it       = '0;
        it.pause = 1'b1;
        pending_items = {pending_items, it};
    endtask

    // Input side: offers queued items, predicts each one as it is transferred.
    always @(posedge i_clk) begin
        logic [IN_DATA_W-1:0] word;
        logic                 offer;
        logic                 calm;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (cur_item.mode == MODE_WRITE) begin
                    rule_table[cur_item.slot] = '{actions: cur_item.act, dir: cur_item.dir,
                                                  prefix: cur_item.plen, addr: cur_item.addr};
                    rule_live[cur_item.slot] = cur_item.en;
                    expected_verdicts = {expected_verdicts, verdict_t'(0)};
                end else begin
                    expected_verdicts = {expected_verdicts,
                                         classify_call(cur_item.src, cur_item.dst,
                                                       cur_item.flags)};
                end
                n_accepted <= n_accepted + 1;
            end
            if (!s_valid || s_ready) begin
                offer = 1'b0;
                calm  = (n_accepted >= 300) && (n_accepted < 420);
                if (pending_items.size() != 0 && pending_items[0].pause) begin
                    if (!s_valid && n_accepted == n_checked) begin
                        pending_items.delete(0);
                    end
                end else if (pending_items.size() != 0 &&
                             (calm || $urandom_range(99) >= 32)) begin
                    cur_item = pending_items[0];
                    pending_items.delete(0);
                    word = '0;
                    word[IN_SLOT_LSB   +: SLOT_IN_W] = cur_item.slot;
                    word[IN_EN_LSB]                  = cur_item.en;
                    word[IN_ADDR_LSB   +: ADDR_W]    = cur_item.addr;
                    word[IN_PREFIX_LSB +: PREFIX_W]  = cur_item.plen;
                    word[IN_DIR_LSB    +: DIR_W]     = cur_item.dir;
                    word[IN_ACT_LSB    +: ACT_W]     = cur_item.act;
                    word[IN_SRC_LSB    +: ADDR_W]    = cur_item.src;
                    word[IN_DST_LSB    +: ADDR_W]    = cur_item.dst;
                    word[IN_FLAGS_LSB  +: FLAGS_W]   = cur_item.flags;
                    s_data <= word;
                    s_user <= cur_item.mode;
                    offer = 1'b1;
                end
                s_valid <= offer;
            end
        end
    end

    // A single long receiver stall somewhere in the random part.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cyc       <= 0;
            hold_left <= 0;
        end else begin
            cyc <= cyc + 1;
            if (cyc == 3000) begin
                hold_left <= 300;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end
        end
    end

    // Output side: checks every transfer against the oldest prediction.
    always @(posedge i_clk) begin
        verdict_t got;
        verdict_t want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_ready && m_valid) begin
                got = m_data;
                if (expected_verdicts.size() == 0) begin
                    report_mismatch("result with nothing outstanding", 0, 32'(got));
                end else begin
                    want = expected_verdicts[0];
                    expected_verdicts.delete(0);
                    if (got.matched !== want.matched) begin
                        report_mismatch("matched", 32'(want.matched), 32'(got.matched));
                    end
                    if (got.slot !== want.slot) begin
                        report_mismatch("match_slot", 32'(want.slot), 32'(got.slot));
                    end
                    if (got.flags !== want.flags) begin
                        report_mismatch("flags_out", 32'(want.flags), 32'(got.flags));
                    end
                end
                n_checked <= n_checked + 1;
            end
            m_ready <= (hold_left == 0) &&
                       ((n_checked >= 300 && n_checked < 420) || $urandom_range(99) >= 32);
        end
    end

    initial begin
        int unsigned pick;
        logic [31:0] a;
        logic [31:0] b;
        foreach (rule_table[k]) begin
            rule_table[k] = '0;
            seed_addr[k]  = $urandom;
        end

        // Directed part: empty table, catch-all rule, saturated and odd codes.
        add_call(32'h0000_0000, 32'h0000_0000, 11'h7FF);
        add_call(32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'h000);
        add_rule(4'd15, 1'b1, 32'h0000_0000, 6'd0, DIR_EITHER, {MOS_NONE, {8{ACT_ON}}});
        add_call($urandom, $urandom, 11'h000);
        add_rule(4'd0, 1'b1, 32'hFFFF_FFFF, 6'd32, DIR_SRC, {MOS_A, {8{ACT_OFF}}});
        add_call(32'hFFFF_FFFF, 32'h0000_0000, 11'h7FF);
        add_call(32'h0000_0000, 32'hFFFF_FFFF, 11'h7FF);
        add_rule(4'd1, 1'b1, 32'hC0A8_0000, 6'd16, DIR_DST, {MOS_RSVD_LO, {8{CODE_RSVD}}});
        add_call(32'h0102_0304, 32'hC0A8_ABCD, 11'h555);
        add_rule(4'd2, 1'b1, 32'h0A00_0001, 6'd40, DIR_EITHER,
                 {MOS_OFF, {7{CODE_NONE}}, ACT_OFF});
        add_call(32'h0A00_0001, 32'h0000_0000, 11'h7FF);
        add_call(32'h0A00_0002, 32'h0A00_0003, 11'h7FF);
        add_rule(4'd3, 1'b1, 32'h0000_0000, 6'd0, DIR_NEVER, {MOS_AB, {8{ACT_ON}}});
        add_call(32'h1234_5678, 32'h8765_4321, 11'h000);
        add_rule(4'd4, 1'b1, 32'h7F00_0000, 6'd8, DIR_EITHER, {MOS_AB, 16'h9A6B});
        add_call(32'h0000_0000, 32'h7F00_00FF, 11'h000);
        add_rule(4'd5, 1'b1, 32'h8000_0000, 6'd1, DIR_SRC, {MOS_RSVD_HI, 16'h0000});
        add_call(32'h8000_0001, 32'h0000_0000, 11'h7FF);
        add_rule(4'd6, 1'b1, 32'h4000_0000, 6'd63, DIR_DST, {MOS_B, 16'h0000});
        add_call(32'h0000_0000, 32'h4000_0000, 11'h000);
        add_rule(4'd15, 1'b0, 32'h0000_0000, 6'd0, DIR_EITHER, 19'h0);
        add_call(32'h1111_1111, 32'h2222_2222, 11'h7FF);
        add_pause();

        // Random part: rules mixed with calls aimed near the rule addresses.
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 280 == 140) begin
                add_pause();
            end
            if ($urandom_range(99) < 25) begin
                add_rule(SLOT_IN_W'($urandom), $urandom_range(99) >= 15,
                         ($urandom_range(3) == 0) ? seed_addr[$urandom_range(15)] : $urandom,
                         ($urandom_range(9) == 0) ? PREFIX_W'($urandom_range(63, 33))
                                                  : PREFIX_W'($urandom_range(32, 0)),
                         ($urandom_range(9) == 0) ? DIR_NEVER
                                                  : DIR_W'($urandom_range(2, 0)),
                         ACT_W'($urandom));
            end else begin
                pick = $urandom_range(15);
                a = seed_addr[pick] ^ ($urandom >> $urandom_range(32, 1));
                pick = $urandom_range(15);
                b = seed_addr[pick] ^ ($urandom >> $urandom_range(32, 1));
                case ($urandom_range(3))
                    0: add_call(a, $urandom, FLAGS_W'($urandom));
                    1: add_call($urandom, b, FLAGS_W'($urandom));
                    2: add_call(a, b, FLAGS_W'($urandom));
                    default: add_call($urandom, $urandom, FLAGS_W'($urandom));
                endcase
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || s_valid || n_checked != n_accepted) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_verdicts.size() != 0) begin
            report_mismatch("results never delivered", 0, expected_verdicts.size());
        end
        if (n_err == 0) begin
            $display("PASS ip_prefix_rule_classifier");
        end else begin
            $display("FAIL ip_prefix_rule_classifier");
        end
        $finish;
    end

    initial begin
        #800000;
        $display("FAIL ip_prefix_rule_classifier");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/iprc_pkg.sv
hw/rtl/iprc_ctrl.sv
hw/rtl/iprc_dp.sv
hw/rtl/ip_prefix_rule_classifier.sv
dv/ip_prefix_rule_classifier_tb.sv
